// ===== rtl/cfts_pkg.sv =====
// Shared types and codes for the cooperative thread scheduler.
`timescale 1ns / 1ps

package cfts_pkg;

  localparam int unsigned NUM_IDS = 16;
  localparam int unsigned TID_W   = 4;
  localparam int unsigned PID_W   = 8;

  localparam logic       CMD_READY = 1'b0;
  localparam logic       CMD_YIELD = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef logic [TID_W-1:0] tid_t;
  typedef logic [PID_W-1:0] pid_t;

  typedef struct packed {
    logic       cmd;
    tid_t       thread_id;
    pid_t       process_id;
    logic       from_valid;
    logic       blocked;
    logic       destroy;
  } in_t;

  typedef struct packed {
    tid_t       next_thread;
    logic       do_switch;
    logic       switch_space;
    logic       destroy_from;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic cap;
    logic rd2;
    logic exec;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctl_stat_t;

endpackage

// ===== rtl/cfts_ctrl.sv =====
// Sequencing state machine for the thread scheduler.
`timescale 1ns / 1ps

module cfts_ctrl
  import cfts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign cmd.cap  = in_valid && in_ready;
  assign cmd.rd2  = (state_r == S_READ);
  assign cmd.exec = (state_r == S_EXEC) && stat.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/cfts_dp.sv =====
// Ready queue, owner table, pointers and result register of the thread scheduler.
`timescale 1ns / 1ps

module cfts_dp
  import cfts_pkg::*;
#(
  parameter int unsigned MAX_THREADS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_t       in_data,
  input  ctl_cmd_t  cmd,
  output ctl_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  localparam int unsigned PTR_W = $clog2(MAX_THREADS);
  localparam int unsigned CNT_W = $clog2(MAX_THREADS + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_THREADS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_THREADS);

  tid_t queue_mem [MAX_THREADS];
  pid_t owner_mem [NUM_IDS];

  in_t              req_r;
  tid_t             qdata_r;
  pid_t             own_from_r;
  pid_t             own_to_r;
  logic [PTR_W-1:0] head_r;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_r;
  logic [PTR_W-1:0] tail_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             push;
  logic             pop;
  tid_t             push_tid;
  out_t             res;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == LAST_PTR) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    logic empty;
    logic full;
    logic can_run;
    empty    = (count_r == '0);
    full     = (count_r == FULL_CNT);
    can_run  = !(req_r.blocked || req_r.destroy);
    push     = 1'b0;
    pop      = 1'b0;
    push_tid = req_r.thread_id;
    res      = '0;
    res.status = STAT_OK;
    if (req_r.cmd == CMD_READY) begin
      if (full) begin
        res.status = STAT_FULL;
      end else begin
        push = 1'b1;
      end
    end else if (empty) begin
      if (req_r.from_valid && can_run) begin
        res.next_thread = req_r.thread_id;
      end else begin
        res.status = STAT_NONE;
      end
    end else begin
      pop = 1'b1;
      res.next_thread = qdata_r;
      if (!req_r.from_valid || (qdata_r != req_r.thread_id)) begin
        res.do_switch = 1'b1;
        if (req_r.from_valid) begin
          push             = can_run;
          res.switch_space = (own_from_r != own_to_r);
          res.destroy_from = req_r.destroy;
        end else begin
          res.switch_space = 1'b1;
        end
      end
    end
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.exec) begin
      if (pop) begin
        head_nxt = ptr_inc(head_r);
      end
      if (push) begin
        tail_nxt = ptr_inc(tail_r);
      end
      count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r      <= in_data;
      qdata_r    <= queue_mem[head_r];
      own_from_r <= owner_mem[in_data.thread_id];
    end
    if (cmd.rd2) begin
      own_to_r <= owner_mem[qdata_r];
    end
    if (cmd.exec && (req_r.cmd == CMD_READY)) begin
      owner_mem[req_r.thread_id] <= req_r.process_id;
    end
    if (cmd.exec && push) begin
      queue_mem[tail_r] <= push_tid;
    end
    if (cmd.exec) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// ===== rtl/cooperative_fifo_thread_scheduler.sv =====
// Top level of the cooperative FIFO thread scheduler.
//
// Input channel in_valid/in_ready/in_data carries one command per transfer:
// make a thread ready (record its owner, append to the ready queue) or
// yield from the current thread (pop the head, re-queue the current thread if runnable).
// Every command yields exactly one result on out_valid/out_ready/out_data.
// One command is handled at a time: accept, owner read of the popped
// thread, then execute; out_valid and the result are registered by the
// execute step, and the input accepts again once that step is done. The
// owner lookup of the popped head depends on the registered queue read,
// which is why the owner read is a step of its own. A result waits in the
// output register; while the receiver stalls, the execute step holds and no
// new command is taken once the pipeline has filled. Reset empties the
// queue and drops any pending result; queue and owner contents are not
// cleared and there is no clearing pass.
`timescale 1ns / 1ps

module cooperative_fifo_thread_scheduler
  import cfts_pkg::*;
#(
  parameter int unsigned MAX_THREADS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  cfts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.rd2, cmd.exec}))
    else $error("scheduler commands overlap");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_read_follows_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd2 |-> $past(cmd.cap))
    else $error("owner read without a captured command");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid)
    else $error("executed command produced no result");
`endif

endmodule
